>>> design/lrs_pkg.sv
// Package: shared types and constants of the LRU recency stack.
package lrs_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned ID_WIDTH = 16;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_EVICT  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic [ID_WIDTH-1:0] pid;
    logic [ID_WIDTH-1:0] aid;
  } entry_t;

  typedef struct packed {
    op_e         operation;
    logic [15:0] process_id;
    logic [15:0] alloc_id;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] out_process_id;
    logic [15:0] out_alloc_id;
    logic [4:0]  entry_count;
  } rsp_t;

  // Control broadcast to every cell for the current request.
  typedef struct packed {
    logic   push;
    logic   remove;
    logic   evict;
    entry_t key;
  } cell_ctl_t;

endpackage

>>> design/lru_recency_stack_top.sv
// Module: top level of the LRU recency stack, a row of cells with a shared count.
//
// A request is taken at any clock edge where start is high; busy stays low, so one
// request enters every cycle. Its response appears on rsp_o one cycle later, marked
// by done_o for exactly one cycle, and must be captured then: there is no stall.
// The stack is a row of DEPTH cells, cell 0 the most recent entry. A push shifts
// every cell down one place and loads the new entry into cell 0; a remove compares
// the key in all cells at once, takes the topmost match and shifts the cells below
// it up one place; an evict drops the bottom occupied cell. Each operation finishes
// in the single cycle the cells take to compare and shift. A push onto a full stack
// is refused with status full, a remove with no match reports not found, and a
// remove or evict on an empty stack reports empty. Returned ids are zero unless an
// entry left the stack; entry_count is the number held after the operation.
module lru_recency_stack_top
  import lrs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;
  rsp_t             rsp_q, rsp_d;
  cell_ctl_t        ctl;
  logic             accept, full, empty, found;

  logic   [DEPTH:0]   hit;
  logic   [DEPTH:0]   occ;
  entry_t [DEPTH:0]   sel;
  entry_t [DEPTH-1:0] data;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);

  // Broadcast the decoded request; refused operations do not touch the cells.
  always_comb begin
    ctl.key.pid = ID_WIDTH'(req_i.process_id);
    ctl.key.aid = ID_WIDTH'(req_i.alloc_id);
    ctl.push    = accept && (req_i.operation == OP_PUSH) && !full;
    ctl.remove  = accept && (req_i.operation == OP_REMOVE);
    ctl.evict   = accept && (req_i.operation == OP_EVICT);
  end

  // Seed the match and selection chains at the top of the row.
  assign hit[0] = 1'b0;
  assign sel[0] = '0;
  assign occ[DEPTH] = 1'b0;
  assign found = hit[DEPTH];

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    entry_t up_data, dn_data;

    assign occ[gi] = (CNT_W'(gi) < count_q);

    if (gi == 0) begin : g_top
      assign up_data = ctl.key;
    end else begin : g_mid
      assign up_data = data[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_bot
      assign dn_data = '0;
    end else begin : g_low
      assign dn_data = data[gi+1];
    end

    lrs_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .occ_i      (occ[gi]),
      .occ_next_i (occ[gi+1]),
      .up_data_i  (up_data),
      .dn_data_i  (dn_data),
      .hit_i      (hit[gi]),
      .hit_o      (hit[gi+1]),
      .sel_i      (sel[gi]),
      .sel_o      (sel[gi+1]),
      .data_o     (data[gi])
    );
  end

  // Build the response and the next count.
  always_comb begin
    rsp_d   = '0;
    count_d = count_q;
    rsp_d.status = ST_OK;
    unique case (req_i.operation)
      OP_PUSH: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else if (!found) begin
          rsp_d.status = ST_NOT_FOUND;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_EVICT: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
    rsp_d.out_process_id = 16'(sel[DEPTH].pid);
    rsp_d.out_alloc_id   = 16'(sel[DEPTH].aid);
    rsp_d.entry_count    = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Hold the response payload; the strobe marks when it is fresh.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // Every request yields exactly one response in the next cycle.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("response strobe missing");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("response strobe without request");

  // An accepted push on a non-full stack raises the count by one.
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.push |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("push did not grow the stack");

  // A successful remove returns the requested key.
  a_remove_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.remove && found) |=> (rsp_o.status == ST_OK
      && rsp_o.out_process_id == $past(req_i.process_id)
      && rsp_o.out_alloc_id == $past(req_i.alloc_id)))
    else $error("remove returned wrong entry");

endmodule

>>> design/lrs_cell.sv
// Module: one stack cell holding one entry, with match and hand-off logic.
module lrs_cell
  import lrs_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      occ_i,
  input  logic      occ_next_i,
  input  entry_t    up_data_i,
  input  entry_t    dn_data_i,
  input  logic      hit_i,
  output logic      hit_o,
  input  entry_t    sel_i,
  output entry_t    sel_o,
  output entry_t    data_o
);

  entry_t data_q, data_d;
  logic   match, take, pick;

  assign match = occ_i && (data_q == ctl_i.key);
  assign hit_o = hit_i | match;
  // Topmost match leaves the stack; the bottom occupied cell is the evict victim.
  assign take  = ctl_i.remove && match && !hit_i;
  assign pick  = ctl_i.evict && occ_i && !occ_next_i;
  assign sel_o = (take || pick) ? data_q : sel_i;
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    if (ctl_i.push) begin
      data_d = up_data_i;
    end else if (ctl_i.remove && hit_o) begin
      data_d = dn_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule
